>>> rtl/cbis_pkg.sv
// ----------------------------------------------------------------------------
// cbis_pkg: shared types and constants of the bilinear image sampler
// Controller states, command and status bundles, register indexes and the
// fade weight arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none
package cbis_pkg;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;
    localparam logic [1:0] REG_FADE     = 2'd3;

    localparam logic [1:0] FADE_LINEAR  = 2'd0;
    localparam logic [1:0] FADE_CUBIC   = 2'd1;
    localparam logic [1:0] FADE_QUINTIC = 2'd2;

    localparam int CFG_BITS = 9;
    localparam int Q16      = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FADE,
        ST_READ,
        ST_BLEND,
        ST_ROUND,
        ST_OUT
    } cbis_state_t;

    typedef struct packed {
        logic       store_write;
        logic       load_item;
        logic       fade_start;
        logic       read_start;
        logic       blend_start;
        logic       round_start;
        logic       next_channel;
    } cbis_cmd_t;

    typedef struct packed {
        logic       fade_done;
        logic       read_done;
        logic       blend_done;
        logic       last_channel;
    } cbis_status_t;

endpackage
`default_nettype wire

>>> rtl/cbis_ctrl.sv
// ----------------------------------------------------------------------------
// cbis_ctrl: sequencer of the bilinear image sampler
// Steps write items into the store and walks interpolation items through
// weight, neighbour read, blend and rounding, one channel at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module cbis_ctrl
    import cbis_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         s_operation,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire cbis_status_t status,
    output cbis_cmd_t         cmd
);

    cbis_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = s_operation ? ST_FADE : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.store_write = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FADE: begin
                cmd.fade_start = 1'b1;
                if (status.fade_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_start = 1'b1;
                if (status.read_done) begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                cmd.blend_start = 1'b1;
                if (status.blend_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_start = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last_channel) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_channel = 1'b1;
                        state_next       = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/cbis_datapath.sv
// ----------------------------------------------------------------------------
// cbis_datapath: image store and arithmetic of the bilinear image sampler
// Holds the sample memory, computes faded weights over several steps, reads
// four neighbours through one port and blends them with one multiplier a step.
// ----------------------------------------------------------------------------
`default_nettype none
module cbis_datapath
    import cbis_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic [7:0]         s_write_column,
    input  wire logic [7:0]         s_write_row,
    input  wire logic [1:0]         s_write_channel,
    input  wire logic signed [15:0] s_write_value,
    input  wire logic [15:0]        s_coord_x,
    input  wire logic [15:0]        s_coord_y,
    input  wire cbis_cmd_t          cmd,
    output cbis_status_t            status,
    output logic signed [15:0]      m_sample_value,
    output logic [1:0]              m_out_channel,
    output logic                    m_last_channel
);

    localparam int XB   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AB   = YB + XB + CB;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int IB   = 16 - FRAC_BITS;
    localparam int LB   = CB + 1;

    // configuration
    logic [8:0] width_reg, height_reg;
    logic [2:0] chans_reg;
    logic [1:0] fade_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            chans_reg  <= 3'd1;
            fade_reg   <= FADE_LINEAR;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg  <= cfg_data;
                REG_HEIGHT:   height_reg <= cfg_data;
                REG_CHANNELS: chans_reg  <= cfg_data[2:0];
                REG_FADE:     fade_reg   <= cfg_data[1:0];
                default:      fade_reg   <= fade_reg;
            endcase
        end
    end

    logic [12:0] w_eff, h_eff;
    logic [3:0]  c_eff;
    always_comb begin
        w_eff = (width_reg == 9'd0) ? 13'd1 : 13'(width_reg);
        if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
        h_eff = (height_reg == 9'd0) ? 13'd1 : 13'(height_reg);
        if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
        c_eff = (chans_reg == 3'd0) ? 4'd1 : 4'(chans_reg);
        if (c_eff > 4'(MAX_CHANNELS)) c_eff = 4'(MAX_CHANNELS);
    end

    // item capture
    logic [7:0]  wcol_reg, wrow_reg;
    logic [1:0]  wch_reg;
    logic signed [15:0] wval_reg;
    logic [IB-1:0] xi_reg, yi_reg;
    logic [16:0]   tx_reg, ty_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            wcol_reg <= s_write_column;
            wrow_reg <= s_write_row;
            wch_reg  <= s_write_channel;
            wval_reg <= s_write_value;
            xi_reg   <= s_coord_x[15 -: IB];
            yi_reg   <= s_coord_y[15 -: IB];
            tx_reg   <= {1'b0, s_coord_x[FRAC_BITS-1:0], {IB{1'b0}}};
            ty_reg   <= {1'b0, s_coord_y[FRAC_BITS-1:0], {IB{1'b0}}};
        end
    end

    // clamped neighbour coordinates
    logic [12:0] x0, x1, y0, y1;
    always_comb begin
        x0 = 13'(xi_reg);
        x1 = 13'(xi_reg) + 13'd1;
        y0 = 13'(yi_reg);
        y1 = 13'(yi_reg) + 13'd1;
        if (x0 > w_eff - 13'd1) x0 = w_eff - 13'd1;
        if (x1 > w_eff - 13'd1) x1 = w_eff - 13'd1;
        if (y0 > h_eff - 13'd1) y0 = h_eff - 13'd1;
        if (y1 > h_eff - 13'd1) y1 = h_eff - 13'd1;
    end

    // image store
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic [AB-1:0] wr_addr, rd_addr;
    logic          wr_ok;
    logic signed [SAMPLE_BITS-1:0] wr_data;

    localparam logic signed [15:0] SMAX16 = (SAMPLE_BITS >= 16) ? 16'sh7fff
                                          : 16'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [15:0] SMIN16 = ~SMAX16;

    always_comb begin
        wr_ok = (32'(wcol_reg) < MAX_WIDTH) && (32'(wrow_reg) < MAX_HEIGHT)
              && (32'(wch_reg) < MAX_CHANNELS);
        wr_addr = AB'({32'(wrow_reg) * MAX_WIDTH + 32'(wcol_reg)} * MAX_CHANNELS
                      + 32'(wch_reg));
        if (wval_reg > SMAX16)      wr_data = SAMPLE_BITS'(SMAX16);
        else if (wval_reg < SMIN16) wr_data = SAMPLE_BITS'(SMIN16);
        else                        wr_data = SAMPLE_BITS'(wval_reg);
    end

    logic [1:0]    nb_reg;
    logic [2:0]    rcnt_reg;
    logic [LB-1:0] ch_reg;
    logic [12:0]   rx, ry;

    always_comb begin
        rx = nb_reg[0] ? x1 : x0;
        ry = nb_reg[1] ? y1 : y0;
        rd_addr = AB'((32'(ry) * MAX_WIDTH + 32'(rx)) * MAX_CHANNELS + 32'(ch_reg));
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_write && wr_ok) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // neighbour read sequence: issue four addresses, catch four samples
    logic signed [SAMPLE_BITS-1:0] px_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg   <= '0;
            rcnt_reg <= '0;
            ch_reg   <= '0;
        end else begin
            if (cmd.load_item) begin
                ch_reg <= '0;
            end else if (cmd.next_channel) begin
                ch_reg <= ch_reg + LB'(1);
            end
            if (cmd.read_start && rcnt_reg != 3'd5) begin
                rcnt_reg <= rcnt_reg + 3'd1;
                nb_reg   <= nb_reg + 2'd1;
            end else if (!cmd.read_start) begin
                rcnt_reg <= '0;
                nb_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_start && rcnt_reg >= 3'd1 && rcnt_reg <= 3'd4) begin
            px_reg[2'(rcnt_reg - 3'd1)] <= rd_reg;
        end
    end

    assign status.read_done    = cmd.read_start && (rcnt_reg == 3'd5);
    assign status.last_channel = (4'(ch_reg) + 4'd1 == c_eff);

    // fade weights: one 34x17 multiply per step
    logic [2:0]  fstep_reg;
    logic        faxis_reg;
    logic [49:0] prod_reg;
    logic [33:0] ma;
    logic [16:0] mb;
    logic [16:0] t;
    logic [33:0] tt_reg, t3_reg, p16_reg;
    logic [16:0] wx_reg, wy_reg;
    logic [16:0] wcap;
    logic [49:0] mul;
    logic        fade_fin;

    assign t   = faxis_reg ? ty_reg : tx_reg;
    assign mul = 50'(ma) * 50'(mb);

    always_comb begin
        ma = '0;
        mb = '0;
        case (fstep_reg)
            3'd0: begin ma = 34'(t);            mb = t; end
            3'd1: begin ma = prod_reg[33:0];    mb = t; end
            3'd3: begin ma = p16_reg;           mb = t3_reg[16:0]; end
            default: begin ma = '0;             mb = '0; end
        endcase
    end

    // quintic polynomial: (6t^2 - 15t*2^16 + 10*2^32 + 2^15) >> 16
    logic [51:0] poly;
    assign poly = 52'(tt_reg) * 52'd6 + (52'd10 << 32) - 52'(t) * 52'd15 * 52'd65536
                + (52'd1 << 15);

    logic [50:0] cub;
    assign cub = 51'(tt_reg) * 51'(3 * 65536) - 51'(prod_reg) * 51'd2 + (51'd1 << 31);

    always_comb begin
        wcap = t;
        fade_fin = 1'b0;
        case (fade_reg)
            FADE_CUBIC: begin
                fade_fin = (fstep_reg == 3'd2);
                wcap = (cub[50:32] > 19'd65536) ? 17'd65536 : 17'(cub[50:32]);
            end
            FADE_QUINTIC: begin
                fade_fin = (fstep_reg == 3'd4);
                wcap = ((prod_reg + 50'd32768) >> 16 > 50'd65536) ? 17'd65536
                     : 17'((prod_reg + 50'd32768) >> 16);
            end
            default: begin
                fade_fin = 1'b1;
                wcap = t;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstep_reg <= '0;
            faxis_reg <= 1'b0;
        end else if (cmd.fade_start) begin
            if (fade_fin) begin
                fstep_reg <= '0;
                faxis_reg <= ~faxis_reg;
            end else begin
                fstep_reg <= fstep_reg + 3'd1;
            end
        end else begin
            fstep_reg <= '0;
            faxis_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fade_start) begin
            prod_reg <= mul;
            case (fstep_reg)
                3'd1: tt_reg <= prod_reg[33:0];
                3'd2: begin
                    t3_reg  <= 34'((prod_reg + (50'd1 << 31)) >> 32);
                    p16_reg <= 34'(poly >> 16);
                end
                default: tt_reg <= tt_reg;
            endcase
            if (fade_fin) begin
                if (faxis_reg) wy_reg <= wcap;
                else           wx_reg <= wcap;
            end
        end
    end

    assign status.fade_done = cmd.fade_start && fade_fin && faxis_reg;

    // blend: six multiplies, one per step
    localparam int PB = SAMPLE_BITS + 18;
    localparam int RB = PB + 18;
    logic [2:0]              bstep_reg;
    logic signed [PB-1:0]    top_reg, bot_reg;
    logic signed [RB-1:0]    acc_reg;
    logic signed [RB-1:0]    bmul;
    logic signed [PB-1:0]    bop;
    logic signed [17:0]      bw;
    logic signed [17:0]      ux, uy, swx, swy;

    assign ux  = 18'sd65536 - $signed({1'b0, wx_reg});
    assign uy  = 18'sd65536 - $signed({1'b0, wy_reg});
    assign swx = $signed({1'b0, wx_reg});
    assign swy = $signed({1'b0, wy_reg});

    always_comb begin
        bop = '0;
        bw  = '0;
        case (bstep_reg)
            3'd0: begin bop = PB'(px_reg[0]); bw = ux;  end
            3'd1: begin bop = PB'(px_reg[1]); bw = swx; end
            3'd2: begin bop = PB'(px_reg[2]); bw = ux;  end
            3'd3: begin bop = PB'(px_reg[3]); bw = swx; end
            3'd4: begin bop = top_reg;        bw = uy;  end
            3'd5: begin bop = bot_reg;        bw = swy; end
            default: begin bop = '0;          bw = '0;  end
        endcase
        bmul = RB'(bop) * RB'(bw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstep_reg <= '0;
        end else if (cmd.blend_start && bstep_reg != 3'd6) begin
            bstep_reg <= bstep_reg + 3'd1;
        end else begin
            bstep_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.blend_start) begin
            case (bstep_reg)
                3'd0: top_reg <= PB'(bmul);
                3'd1: top_reg <= top_reg + PB'(bmul);
                3'd2: bot_reg <= PB'(bmul);
                3'd3: bot_reg <= bot_reg + PB'(bmul);
                3'd4: acc_reg <= bmul;
                3'd5: acc_reg <= acc_reg + bmul;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign status.blend_done = cmd.blend_start && (bstep_reg == 3'd6);

    // round to nearest, ties up, then saturate
    logic signed [RB-1:0] rnd;
    logic signed [RB-33:0] q;
    logic signed [15:0] res_reg;
    logic signed [RB-33:0] smax_w, smin_w;

    assign rnd    = acc_reg + (RB'(1) <<< 31);
    assign q      = rnd[RB-1:32];
    assign smax_w = (RB-32)'(SMAX16);
    assign smin_w = (RB-32)'(SMIN16);

    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            if (q > smax_w)      res_reg <= SMAX16;
            else if (q < smin_w) res_reg <= SMIN16;
            else                 res_reg <= 16'(q);
        end
    end

    assign m_sample_value = res_reg;
    assign m_out_channel  = 2'(ch_reg);
    assign m_last_channel = status.last_channel;

endmodule
`default_nettype wire

>>> rtl/clamped_bilinear_image_sampler.sv
// ----------------------------------------------------------------------------
// clamped_bilinear_image_sampler: top level
// Image store with clamp-to-edge bilinear sampling and optional fade weights.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): a write item stores one sample; an
// interpolation item yields channel_count result items on m_valid/m_ready,
// channel 0 first, m_last_channel set on the final one.
// Write item: accepted in the idle state and stored in the cycle after; the
// next item is taken once the sequencer has passed ST_WRITE back to idle.
// Interpolation: linear, cubic or quintic fade weights for both axes on one shared
// multiplier, then per channel neighbour reads through the single memory read port,
// blending on one multiplier and rounding before the result is shown.
// One item is in flight at a time; s_ready is low until its last result is taken.
// A stalled receiver holds the result and the sequencer in place.
// Reset clears the configuration to width 256, height 256, one channel and
// linear weighting; the image store keeps no reset and is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module clamped_bilinear_image_sampler
    import cbis_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [7:0]         s_write_column,
    input  wire logic [7:0]         s_write_row,
    input  wire logic [1:0]         s_write_channel,
    input  wire logic signed [15:0] s_write_value,
    input  wire logic [15:0]        s_coord_x,
    input  wire logic [15:0]        s_coord_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_sample_value,
    output logic [1:0]              m_out_channel,
    output logic                    m_last_channel
);

    cbis_cmd_t    cmd;
    cbis_status_t status;

    cbis_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    cbis_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_write_column  (s_write_column),
        .s_write_row     (s_write_row),
        .s_write_channel (s_write_channel),
        .s_write_value   (s_write_value),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .cmd             (cmd),
        .status          (status),
        .m_sample_value  (m_sample_value),
        .m_out_channel   (m_out_channel),
        .m_last_channel  (m_last_channel)
    );

endmodule
`default_nettype wire

>>> rtl/cbis_checker.sv
// ----------------------------------------------------------------------------
// cbis_checker: port-level checks of the bilinear image sampler
// Watches handshakes and result ordering on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module cbis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_sample_value,
    input wire logic [1:0]  m_out_channel,
    input wire logic        m_last_channel
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_value)
                               && $stable(m_out_channel))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    a_chan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_channel |=> !m_valid)
        else $error("next channel shown without read cycle");

    a_first_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result shown right after accept");

endmodule

bind clamped_bilinear_image_sampler cbis_checker u_cbis_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sample_value (m_sample_value),
    .m_out_channel  (m_out_channel),
    .m_last_channel (m_last_channel)
);
`default_nettype wire

>>> verif/clamped_bilinear_image_sampler_tb.sv
// ----------------------------------------------------------------------------
// clamped_bilinear_image_sampler_tb: self-checking testbench of the sampler
// Loads image samples through write items and sends interpolation items at
// edge, clamped and random coordinates under all fade modes and several image
// shapes. Every pixel that a sample item reads is written first. A predictor
// in the bench computes each interpolated channel value, and a checker
// compares every result item against the oldest prediction. Both sides idle
// at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none
module clamped_bilinear_image_sampler_tb
    import cbis_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STORE_DEPTH = 256 * 256 * 4;
    localparam int  CYCLE_LIMIT = 600000;
    localparam bit  OP_WRITE    = 1'b0;
    localparam bit  OP_SAMPLE   = 1'b1;

    typedef struct {
        logic signed [15:0] value;
        logic [1:0]         channel;
        logic               last;
    } channel_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [8:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = 1'b0;
    logic [7:0]         s_write_column = '0;
    logic [7:0]         s_write_row = '0;
    logic [1:0]         s_write_channel = '0;
    logic signed [15:0] s_write_value = '0;
    logic [15:0]        s_coord_x = '0;
    logic [15:0]        s_coord_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_sample_value;
    logic [1:0]         m_out_channel;
    logic               m_last_channel;

    logic signed [15:0] image_mirror [0:STORE_DEPTH-1];
    bit                 pixel_known  [0:STORE_DEPTH-1];
    logic [8:0]         width_reg = 9'd256;
    logic [8:0]         height_reg = 9'd256;
    logic [2:0]         channels_reg = 3'd1;
    logic [1:0]         fade_reg = FADE_LINEAR;

    channel_result_t    pending_results[$];
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_idle_pct = 0;
    int                 hold_cycles = 0;

    clamped_bilinear_image_sampler u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_write_column  (s_write_column),
        .s_write_row     (s_write_row),
        .s_write_channel (s_write_channel),
        .s_write_value   (s_write_value),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_out_channel   (m_out_channel),
        .m_last_channel  (m_last_channel)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > 256) return 256;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > 256) return 256;
        return int'(height_reg);
    endfunction

    function automatic int eff_channels();
        if (channels_reg == 0) return 1;
        if (channels_reg > 4) return 4;
        return int'(channels_reg);
    endfunction

    function automatic int store_index(int col, int row, int ch);
        return (row * 256 + col) * 4 + ch;
    endfunction

    function automatic longint fade_weight_q16(longint unsigned t);
        longint unsigned w;
        longint unsigned s;
        longint unsigned t3;
        longint unsigned p;
        if (fade_reg == FADE_CUBIC) begin
            s = 3 * 65536 - 2 * t;
            w = (t * t * s + (64'd1 << 31)) >> 32;
        end else if (fade_reg == FADE_QUINTIC) begin
            t3 = (t * t * t + (64'd1 << 31)) >> 32;
            p  = 6 * t * t + 10 * (64'd1 << 32) - 15 * t * 65536;
            p  = (p + (64'd1 << 15)) >> 16;
            w  = (t3 * p + (64'd1 << 15)) >> 16;
        end else begin
            w = t;
        end
        if (w > 65536) w = 65536;
        return longint'(w);
    endfunction

    task automatic corner_pixels(input logic [15:0] cx, input logic [15:0] cy,
                                 output int x0, output int x1,
                                 output int y0, output int y1);
        x0 = int'(cx >> 8);
        y0 = int'(cy >> 8);
        x1 = x0 + 1;
        y1 = y0 + 1;
        if (x0 > eff_width() - 1)  x0 = eff_width() - 1;
        if (x1 > eff_width() - 1)  x1 = eff_width() - 1;
        if (y0 > eff_height() - 1) y0 = eff_height() - 1;
        if (y1 > eff_height() - 1) y1 = eff_height() - 1;
    endtask

    task automatic predict_interpolation(input logic [15:0] cx, input logic [15:0] cy);
        int x0, x1, y0, y1;
        longint wx, wy, ux, uy, top, bot, acc, r;
        channel_result_t res;
        corner_pixels(cx, cy, x0, x1, y0, y1);
        wx = fade_weight_q16(longint'(cx[7:0]) << 8);
        wy = fade_weight_q16(longint'(cy[7:0]) << 8);
        ux = 65536 - wx;
        uy = 65536 - wy;
        for (int ch = 0; ch < eff_channels(); ch++) begin
            top = longint'(image_mirror[store_index(x0, y0, ch)]) * ux
                + longint'(image_mirror[store_index(x1, y0, ch)]) * wx;
            bot = longint'(image_mirror[store_index(x0, y1, ch)]) * ux
                + longint'(image_mirror[store_index(x1, y1, ch)]) * wx;
            acc = top * uy + bot * wy;
            r = (acc + (64'sd1 <<< 31)) >>> 32;
            if (r > 32767)  r = 32767;
            if (r < -32768) r = -32768;
            res.value   = r[15:0];
            res.channel = ch[1:0];
            res.last    = (ch + 1 == eff_channels());
            pending_results.push_back(res);
        end
    endtask

    task automatic send_item(input bit op, input logic [7:0] col, input logic [7:0] row,
                             input logic [1:0] ch, input logic signed [15:0] val,
                             input logic [15:0] cx, input logic [15:0] cy);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? int'($urandom_range(1, 6)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_write_column  <= col;
        s_write_row     <= row;
        s_write_channel <= ch;
        s_write_value   <= val;
        s_coord_x       <= cx;
        s_coord_y       <= cy;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_WRITE) begin
            image_mirror[store_index(int'(col), int'(row), int'(ch))] = val;
            pixel_known[store_index(int'(col), int'(row), int'(ch))]  = 1'b1;
        end else begin
            predict_interpolation(cx, cy);
        end
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_pixel(input int col, input int row, input int ch,
                               input logic signed [15:0] val);
        send_item(OP_WRITE, 8'(col), 8'(row), 2'(ch), val, 16'($urandom), 16'($urandom));
    endtask

    task automatic sample_at(input logic [15:0] cx, input logic [15:0] cy);
        int x0, x1, y0, y1;
        int xs[4], ys[4];
        corner_pixels(cx, cy, x0, x1, y0, y1);
        xs = '{x0, x1, x0, x1};
        ys = '{y0, y0, y1, y1};
        for (int ch = 0; ch < eff_channels(); ch++)
            for (int k = 0; k < 4; k++)
                if (!pixel_known[store_index(xs[k], ys[k], ch)])
                    write_pixel(xs[k], ys[k], ch, random_sample());
        send_item(OP_SAMPLE, 8'($urandom), 8'($urandom), 2'($urandom), 16'($urandom),
                  cx, cy);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [8:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_write <= 1'b0;
        case (idx)
            REG_WIDTH:    width_reg    = val;
            REG_HEIGHT:   height_reg   = val;
            REG_CHANNELS: channels_reg = val[2:0];
            default:      fade_reg     = val[1:0];
        endcase
    endtask

    task automatic set_image(input int w, input int h, input int chans, input logic [1:0] fade);
        drain_results();
        write_register(REG_WIDTH, 9'(w));
        write_register(REG_HEIGHT, 9'(h));
        write_register(REG_CHANNELS, 9'(chans));
        write_register(REG_FADE, 9'(fade));
    endtask

    task automatic test_directed();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        sample_at(16'h0000, 16'h0000);
        set_image(4, 3, 4, FADE_LINEAR);
        write_pixel(0, 0, 0, 16'sh8000);
        write_pixel(1, 0, 0, 16'sh7FFF);
        write_pixel(0, 1, 0, 16'sh7FFF);
        write_pixel(1, 1, 0, 16'sh8000);
        sample_at(16'h0080, 16'h0080);
        sample_at(16'h00FF, 16'h00FF);
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(16'h0380, 16'h0001);
        set_image(4, 3, 4, FADE_CUBIC);
        sample_at(16'h0040, 16'h00C0);
        sample_at(16'h00FF, 16'h0001);
        set_image(4, 3, 4, FADE_QUINTIC);
        sample_at(16'h0040, 16'h00C0);
        sample_at(16'h00FF, 16'h00FF);
        set_image(4, 3, 2, 2'd3);
        sample_at(16'h0140, 16'h0180);
        set_image(0, 0, 0, FADE_LINEAR);
        sample_at(16'h1234, 16'hFF80);
        set_image(511, 511, 7, FADE_QUINTIC);
        sample_at(16'hFF80, 16'hFFC0);
        sample_at(16'h0A55, 16'h05AA);
        set_image(256, 1, 3, FADE_CUBIC);
        sample_at(16'hFEFF, 16'h0780);
    endtask

    task automatic test_random(input int sender_pct, input int receiver_pct, input int count);
        int w, h;
        logic [15:0] cx, cy;
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 12 == 0) begin
                case ($urandom_range(5))
                    0: begin w = 1;   h = 256; end
                    1: begin w = 256; h = 1; end
                    2: begin w = 0;   h = 511; end
                    default: begin
                        w = int'($urandom_range(1, 12));
                        h = int'($urandom_range(1, 12));
                    end
                endcase
                set_image(w, h, int'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
                sender_idle_pct   = sender_pct;
                receiver_idle_pct = receiver_pct;
            end
            if ($urandom_range(9) == 0) begin
                write_pixel(int'($urandom_range(255)), int'($urandom_range(255)),
                            int'($urandom_range(3)), random_sample());
            end else begin
                if ($urandom_range(4) == 0) begin
                    cx = 16'($urandom);
                    cy = 16'($urandom);
                end else begin
                    cx = {8'($urandom_range(0, 14)), 8'($urandom)};
                    cy = {8'($urandom_range(0, 14)), 8'($urandom)};
                end
                sample_at(cx, cy);
            end
        end
    endtask

    task automatic test_backpressure();
        set_image(6, 5, 4, FADE_QUINTIC);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_cycles       = 300;
        for (int i = 0; i < 8; i++)
            sample_at({8'($urandom_range(0, 6)), 8'($urandom)},
                      {8'($urandom_range(0, 5)), 8'($urandom)});
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result: value %0d channel %0d last %0b",
                             m_sample_value, m_out_channel, m_last_channel);
            end else begin
                if (m_sample_value !== pending_results[0].value
                        || m_out_channel !== pending_results[0].channel
                        || m_last_channel !== pending_results[0].last) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 pending_results[0].value, pending_results[0].channel,
                                 pending_results[0].last, m_sample_value,
                                 m_out_channel, m_last_channel);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(26, 67, 16);
        test_random(67, 26, 16);
        test_random(0, 0, 16);
        test_backpressure();
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/cbis_pkg.sv
rtl/cbis_ctrl.sv
rtl/cbis_datapath.sv
rtl/clamped_bilinear_image_sampler.sv
rtl/cbis_checker.sv
verif/clamped_bilinear_image_sampler_tb.sv
